// File: src/vds_pkg.sv
`default_nettype none

package vds_pkg;

  localparam int MAX_HALF_WIDTH_DFLT  = 128;
  localparam int MAX_HALF_HEIGHT_DFLT = 128;
  localparam int SAMPLE_BITS_DFLT     = 16;

  localparam int SAMPLE_W      = 16;
  localparam int AVERAGE_W     = 16;
  localparam int HALF_WIDTH_W  = 8;
  localparam int HALF_HEIGHT_W = 8;
  localparam int HALF_DEPTH_W  = 11;
  localparam int POS_Z_W       = 11;
  localparam int DEPTH_LIMIT   = 1024;
  localparam int CUBE_SHIFT    = 3;

  // wide enough for twice the largest half size
  localparam int DIM_BITS      = 12;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [HALF_WIDTH_W-1:0]  HALF_WIDTH_RST  = 8'd64;
  localparam logic [HALF_HEIGHT_W-1:0] HALF_HEIGHT_RST = 8'd64;
  localparam logic [HALF_DEPTH_W-1:0]  HALF_DEPTH_RST  = 11'd64;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH  = 2'd0,
    REG_HALF_HEIGHT = 2'd1,
    REG_HALF_DEPTH  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [HALF_WIDTH_W-1:0]  half_width;
    logic [HALF_HEIGHT_W-1:0] half_height;
    logic [HALF_DEPTH_W-1:0]  half_depth;
  } vds_cfg_t;

  typedef struct packed {
    logic first;
    logic emit;
    logic last;
  } vds_ctrl_t;

  localparam int CTRL_W = $bits(vds_ctrl_t);

endpackage

`default_nettype wire

// File: src/vds_if.sv
`default_nettype none

interface vds_in_if;
  import vds_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface vds_out_if;
  import vds_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [AVERAGE_W-1:0] average;
  logic                 last;

  modport source (output valid, output average, output last, input ready);
  modport sink (input valid, input average, input last, output ready);
endinterface

`default_nettype wire

// File: src/volume_downsample_2x2x2_unit.sv
`default_nettype none

// 2x2x2 box-filter downsampler. Source voxels enter in raster order (x, then y, then z),
// one item per clock sustained while the output is not stalled; each cube of eight voxels
// yields one average (sum >> 3, truncated), with last set on the final output voxel of the
// volume. The cube's eighth voxel passes the input queue and the partial-sum stage register
// before out_item.valid rises from the output register. Throughput is set by the single
// read/write port pair of the partial-sum RAM (MAX_HALF_WIDTH * MAX_HALF_HEIGHT entries),
// read and written once per item; a same-slot write in the previous cycle is forwarded.
// The RAM needs no clearing after reset: each cube's first voxel writes its entry.
// Sizes are half dimensions (registers at byte addresses 0, 4, 8); zero acts as one,
// oversized values clip. Write them only with the block idle; a position at or past a new
// end wraps as if it were the last one there.
module volume_downsample_2x2x2_unit #(
  parameter int MAX_HALF_WIDTH  = vds_pkg::MAX_HALF_WIDTH_DFLT,
  parameter int MAX_HALF_HEIGHT = vds_pkg::MAX_HALF_HEIGHT_DFLT,
  parameter int SAMPLE_BITS     = vds_pkg::SAMPLE_BITS_DFLT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  vds_in_if.sink                            in_item,
  vds_out_if.source                         out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vds_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [vds_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [vds_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import vds_pkg::*;

  localparam int DEPTH = MAX_HALF_WIDTH * MAX_HALF_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = CTRL_W + AW + SAMPLE_BITS;

  vds_cfg_t               cfg;
  logic                   q_push, q_pop, q_empty, q_full;
  vds_ctrl_t              f_ctrl, b_ctrl;
  logic [AW-1:0]          f_slot, b_slot;
  logic [SAMPLE_BITS-1:0] f_sample, b_sample;
  logic [QW-1:0]          q_in, q_out;

  vds_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vds_front #(
    .MAX_HALF_WIDTH  (MAX_HALF_WIDTH),
    .MAX_HALF_HEIGHT (MAX_HALF_HEIGHT),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .AW              (AW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ctrl   (f_ctrl),
    .q_slot   (f_slot),
    .q_sample (f_sample)
  );

  assign q_in = {f_ctrl, f_slot, f_sample};

  vds_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {b_ctrl, b_slot, b_sample} = q_out;

  vds_back #(
    .MAX_HALF_WIDTH  (MAX_HALF_WIDTH),
    .MAX_HALF_HEIGHT (MAX_HALF_HEIGHT),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .AW              (AW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_ctrl   (b_ctrl),
    .q_slot   (b_slot),
    .q_sample (b_sample),
    .q_pop    (q_pop),
    .out_item (out_item)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_item.ready && !q_push)
    else $error("item taken while queue full");

endmodule

`default_nettype wire

// File: src/vds_ram.sv
`default_nettype none

module vds_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/vds_cfg.sv
`default_nettype none

module vds_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [vds_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [vds_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [vds_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output vds_pkg::vds_cfg_t                    cfg
);
  import vds_pkg::*;

  vds_cfg_t cfg_r;
  vds_cfg_t cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_HALF_WIDTH:  cfg_nxt.half_width  = pwdata[HALF_WIDTH_W-1:0];
        REG_HALF_HEIGHT: cfg_nxt.half_height = pwdata[HALF_HEIGHT_W-1:0];
        REG_HALF_DEPTH:  cfg_nxt.half_depth  = pwdata[HALF_DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_HALF_WIDTH:  prdata = CFG_DATA_W'(cfg_r.half_width);
      REG_HALF_HEIGHT: prdata = CFG_DATA_W'(cfg_r.half_height);
      REG_HALF_DEPTH:  prdata = CFG_DATA_W'(cfg_r.half_depth);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width  <= HALF_WIDTH_RST;
      cfg_r.half_height <= HALF_HEIGHT_RST;
      cfg_r.half_depth  <= HALF_DEPTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/vds_front.sv
`default_nettype none

module vds_front #(
  parameter int MAX_HALF_WIDTH  = vds_pkg::MAX_HALF_WIDTH_DFLT,
  parameter int MAX_HALF_HEIGHT = vds_pkg::MAX_HALF_HEIGHT_DFLT,
  parameter int SAMPLE_BITS     = vds_pkg::SAMPLE_BITS_DFLT,
  parameter int AW              = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vds_pkg::vds_cfg_t               cfg,
  vds_in_if.sink                          in_item,
  input  logic                            q_full,
  output logic                            q_push,
  output vds_pkg::vds_ctrl_t              q_ctrl,
  output logic [AW-1:0]                   q_slot,
  output logic [SAMPLE_BITS-1:0]          q_sample
);
  import vds_pkg::*;

  localparam int XW = $clog2(2 * MAX_HALF_WIDTH);
  localparam int YW = $clog2(2 * MAX_HALF_HEIGHT);

  logic [XW-1:0]       pos_x_r, pos_x_nxt;
  logic [YW-1:0]       pos_y_r, pos_y_nxt;
  logic [POS_Z_W-1:0]  pos_z_r, pos_z_nxt;
  logic [DIM_BITS-1:0] hw, hh, hd;
  logic [DIM_BITS-1:0] hw_raw, hh_raw, hd_raw;
  logic [DIM_BITS-1:0] end_x, end_y, end_z;
  logic                at_x, at_y, at_z;
  logic                accept;
  logic [XW-1:0]       cx;
  logic [YW-1:0]       cy;
  logic [SAMPLE_BITS+SAMPLE_W-1:0] sample_ext;

  assign in_item.ready = !q_full;
  assign accept        = in_item.valid && !q_full;
  assign q_push        = accept;

  assign hw_raw = DIM_BITS'(cfg.half_width);
  assign hh_raw = DIM_BITS'(cfg.half_height);
  assign hd_raw = DIM_BITS'(cfg.half_depth);

  always_comb begin
    hw = hw_raw;
    if (hw_raw == '0) begin
      hw = DIM_BITS'(1);
    end else if (hw_raw > DIM_BITS'(MAX_HALF_WIDTH)) begin
      hw = DIM_BITS'(MAX_HALF_WIDTH);
    end
    hh = hh_raw;
    if (hh_raw == '0) begin
      hh = DIM_BITS'(1);
    end else if (hh_raw > DIM_BITS'(MAX_HALF_HEIGHT)) begin
      hh = DIM_BITS'(MAX_HALF_HEIGHT);
    end
    hd = hd_raw;
    if (hd_raw == '0) begin
      hd = DIM_BITS'(1);
    end else if (hd_raw > DIM_BITS'(DEPTH_LIMIT)) begin
      hd = DIM_BITS'(DEPTH_LIMIT);
    end
  end

  assign end_x = (hw << 1) - DIM_BITS'(1);
  assign end_y = (hh << 1) - DIM_BITS'(1);
  assign end_z = (hd << 1) - DIM_BITS'(1);

  assign at_x = DIM_BITS'(pos_x_r) >= end_x;
  assign at_y = DIM_BITS'(pos_y_r) >= end_y;
  assign at_z = DIM_BITS'(pos_z_r) >= end_z;

  assign cx = pos_x_r >> 1;
  assign cy = pos_y_r >> 1;

  assign q_slot = AW'(cy) * AW'(MAX_HALF_WIDTH) + AW'(cx);

  assign sample_ext = {{SAMPLE_BITS{1'b0}}, in_item.sample};
  assign q_sample   = sample_ext[SAMPLE_BITS-1:0];

  assign q_ctrl.first = !pos_x_r[0] && !pos_y_r[0] && !pos_z_r[0];
  assign q_ctrl.emit  = pos_x_r[0] && pos_y_r[0] && pos_z_r[0];
  assign q_ctrl.last  = at_x && at_y && at_z;

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (accept) begin
      if (!at_x) begin
        pos_x_nxt = pos_x_r + XW'(1);
      end else begin
        pos_x_nxt = '0;
        if (!at_y) begin
          pos_y_nxt = pos_y_r + YW'(1);
        end else begin
          pos_y_nxt = '0;
          pos_z_nxt = at_z ? '0 : pos_z_r + POS_Z_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/vds_queue.sv
`default_nettype none

module vds_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);
  import vds_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/vds_back.sv
`default_nettype none

module vds_back #(
  parameter int MAX_HALF_WIDTH  = vds_pkg::MAX_HALF_WIDTH_DFLT,
  parameter int MAX_HALF_HEIGHT = vds_pkg::MAX_HALF_HEIGHT_DFLT,
  parameter int SAMPLE_BITS     = vds_pkg::SAMPLE_BITS_DFLT,
  parameter int AW              = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  vds_pkg::vds_ctrl_t     q_ctrl,
  input  logic [AW-1:0]          q_slot,
  input  logic [SAMPLE_BITS-1:0] q_sample,
  output logic                   q_pop,
  vds_out_if.source              out_item
);
  import vds_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + CUBE_SHIFT;
  localparam int DEPTH = MAX_HALF_WIDTH * MAX_HALF_HEIGHT;

  logic                   b_valid_r, b_valid_nxt;
  vds_ctrl_t              b_ctrl_r;
  logic [AW-1:0]          b_slot_r;
  logic [SAMPLE_BITS-1:0] b_sample_r;

  logic                   fwd_valid_r;
  logic [AW-1:0]          fwd_slot_r;
  logic [SUM_W-1:0]       fwd_data_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [AVERAGE_W-1:0]   average_r;
  logic                   last_r;

  logic                   fire;
  logic [SUM_W-1:0]       rdata;
  logic [SUM_W-1:0]       base;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] mean;
  logic [SAMPLE_BITS+AVERAGE_W-1:0] mean_ext;

  assign fire  = b_valid_r && (!b_ctrl_r.emit || !out_valid_r || out_item.ready);
  assign q_pop = !q_empty && (!b_valid_r || fire);

  vds_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_sums (
    .clk   (clk),
    .we    (fire),
    .waddr (b_slot_r),
    .wdata (sum),
    .re    (q_pop),
    .raddr (q_slot),
    .rdata (rdata)
  );

  // the write that lands in the same cycle as this item's read is not seen by the RAM
  assign base = (fwd_valid_r && fwd_slot_r == b_slot_r) ? fwd_data_r : rdata;
  assign sum  = b_ctrl_r.first ? SUM_W'(b_sample_r) : base + SUM_W'(b_sample_r);

  assign mean     = sum[SUM_W-1:CUBE_SHIFT];
  assign mean_ext = {{AVERAGE_W{1'b0}}, mean};

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (q_pop) begin
      b_valid_nxt = 1'b1;
    end else if (fire) begin
      b_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire && b_ctrl_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_ctrl_r   <= q_ctrl;
      b_slot_r   <= q_slot;
      b_sample_r <= q_sample;
    end
    if (fire) begin
      fwd_slot_r <= b_slot_r;
      fwd_data_r <= sum;
    end
    if (fire && b_ctrl_r.emit) begin
      average_r <= mean_ext[AVERAGE_W-1:0];
      last_r    <= b_ctrl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  assign out_item.valid   = out_valid_r;
  assign out_item.average = average_r;
  assign out_item.last    = last_r;

endmodule

`default_nettype wire
